>>> design/mscs_pkg.sv
package mscs_pkg;

    localparam int S_TDATA_W = 232;
    localparam int M_TDATA_W = 80;

    localparam int COLOR_W = 24;
    localparam int POS_W   = 24;
    localparam int IDX_W   = 16;
    localparam int NEAR_W  = 25;
    localparam int ALPHA_W = 17;
    localparam int COST_W  = 24;

    localparam int ONE_Q16 = 65536;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam int COORD_BITS_DEF = 12;
    localparam int INDEX_BITS_DEF = 16;

    localparam int SQSUM_W = 52;
    localparam int REM_W   = 30;
    localparam int ROOT_W  = 26;

endpackage

>>> design/matting_sample_cost_select.sv
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | s_tdata candidate pair, s_tuser start_pixel
// m_      | out | m_tvalid/m_tready | m_tdata kept pair, m_tuser improved
//
// the distance divisions form QW = 2*COORD_BITS + 17 quotient bits
// all divisions and square roots run on one shift/compare/subtract unit
// reset clears the kept pair (cost all ones) and the sequencer
// s_tready is high only when the sequencer is idle
// a finished word waits in the output register while the next word is taken
module matting_sample_cost_select #(
    parameter int COORD_BITS = mscs_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = mscs_pkg::INDEX_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pixel_color, fg_color, bg_color, pixel_pos, fg_pos, bg_pos,
    // fg_index, bg_index, fg_near_dist2, bg_near_dist2, zero fill
    input  logic [mscs_pkg::S_TDATA_W-1:0] s_tdata,
    // start_pixel
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // best_fg, best_bg, best_alpha, best_cost, zero fill
    output logic [mscs_pkg::M_TDATA_W-1:0] m_tdata,
    // improved
    output logic                           m_tuser
);

    localparam int C     = COORD_BITS;
    localparam int D2W   = 2 * C + 1;
    localparam int QW    = D2W + 16;
    localparam int SQW   = QW + (QW % 2);
    localparam int SRCW  = mscs_pkg::SQSUM_W;
    localparam int W     = mscs_pkg::REM_W;
    localparam int RW    = mscs_pkg::ROOT_W;
    localparam int KIW   = (INDEX_BITS < mscs_pkg::IDX_W) ? INDEX_BITS : mscs_pkg::IDX_W;
    localparam int CW    = mscs_pkg::COST_W;
    localparam int CSW   = CW + 2;
    localparam int AW    = mscs_pkg::ALPHA_W;
    localparam int NW    = mscs_pkg::NEAR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DOT, S_ADIV, S_RES, S_CSQRT, S_DPREP, S_DDIV, S_DSQRT, S_DONE
    } state_t;

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic       sel_reg;
    logic       start_reg;

    logic [23:0] pix_reg, fgc_reg, bgc_reg, ppos_reg, fpos_reg, bpos_reg;
    logic [15:0] fidx_reg, bidx_reg;
    logic [NW-1:0] fnear_reg, bnear_reg;

    logic signed [19:0] num_reg;
    logic [17:0]        den_reg;
    logic [AW-1:0]      alpha_reg;
    logic [RW-1:0]      absr_reg;
    logic [SRCW-1:0]    src_reg;
    logic [W-1:0]       rem_reg;
    logic [QW-1:0]      quo_reg;
    logic [NW-1:0]      dvs_reg;
    logic [CSW-1:0]     cost_reg;

    logic [KIW-1:0] kfg_reg, kbg_reg;
    logic [AW-1:0]  kalpha_reg;
    logic [CW-1:0]  kcost_reg;

    function automatic logic [C-1:0] coord_y(input logic [23:0] p);
        logic [23:0] t;
        t = p >> COORD_BITS;
        return t[C-1:0];
    endfunction

    // shared shift / compare / subtract unit
    logic          div_mode;
    logic [W-1:0]  shifted, trial, newrem;
    logic          ge;
    logic [QW-1:0] quo_next;

    always_comb begin
        div_mode = (state_reg == S_ADIV) || (state_reg == S_DDIV);
        if (div_mode) begin
            shifted = {rem_reg[W-2:0], src_reg[SRCW-1]};
            trial   = W'(dvs_reg);
        end else begin
            shifted = {rem_reg[W-3:0], src_reg[SRCW-1:SRCW-2]};
            trial   = W'({quo_reg[RW-1:0], 2'b01});
        end
        ge       = shifted >= trial;
        newrem   = ge ? (shifted - trial) : shifted;
        quo_next = {quo_reg[QW-2:0], ge};
    end

    // per-channel arithmetic
    logic [1:0]         ch;
    logic signed [8:0]  dib, dfb;
    logic signed [19:0] tnum, tden;
    logic signed [27:0] prod, r_c, ar_c;

    always_comb begin
        ch   = (state_reg == S_RES) ? cnt_reg[2:1] : cnt_reg[1:0];
        dib  = $signed({1'b0, pix_reg[8*ch +: 8]}) - $signed({1'b0, bgc_reg[8*ch +: 8]});
        dfb  = $signed({1'b0, fgc_reg[8*ch +: 8]}) - $signed({1'b0, bgc_reg[8*ch +: 8]});
        tnum = dib * dfb;
        tden = dfb * dfb;
        prod = $signed({1'b0, alpha_reg}) * dfb;
        r_c  = ($signed(dib) <<< 16) - prod;
        ar_c = r_c[27] ? -r_c : r_c;
    end

    // distance term setup
    logic [23:0]    opos;
    logic [C-1:0]   x0, y0, x1, y1;
    logic [C-1:0]   adx, ady;
    logic [D2W-1:0] d2;
    logic [NW-1:0]  near;

    always_comb begin
        opos = sel_reg ? bpos_reg : fpos_reg;
        near = sel_reg ? bnear_reg : fnear_reg;
        x0   = ppos_reg[C-1:0];
        x1   = opos[C-1:0];
        y0   = coord_y(ppos_reg);
        y1   = coord_y(opos);
        adx  = (x0 >= x1) ? (x0 - x1) : (x1 - x0);
        ady  = (y0 >= y1) ? (y0 - y1) : (y1 - y0);
        d2   = D2W'(adx) * D2W'(adx) + D2W'(ady) * D2W'(ady);
    end

    // final selection
    logic [CW-1:0]  cost_sat, base_cost;
    logic           better;

    always_comb begin
        cost_sat  = (cost_reg > CSW'(mscs_pkg::COST_MAX)) ? mscs_pkg::COST_MAX
                                                          : cost_reg[CW-1:0];
        base_cost = start_reg ? mscs_pkg::COST_MAX : kcost_reg;
        better    = cost_sat < base_cost;
        s_tready  = (state_reg == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            sel_reg    <= 1'b0;
            m_tvalid   <= 1'b0;
            kfg_reg    <= '0;
            kbg_reg    <= '0;
            kalpha_reg <= '0;
            kcost_reg  <= mscs_pkg::COST_MAX;
        end else begin
            if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        start_reg <= s_tuser;
                        pix_reg   <= s_tdata[23:0];
                        fgc_reg   <= s_tdata[47:24];
                        bgc_reg   <= s_tdata[71:48];
                        ppos_reg  <= s_tdata[95:72];
                        fpos_reg  <= s_tdata[119:96];
                        bpos_reg  <= s_tdata[143:120];
                        fidx_reg  <= s_tdata[159:144];
                        bidx_reg  <= s_tdata[175:160];
                        fnear_reg <= s_tdata[200:176];
                        bnear_reg <= s_tdata[225:201];
                        num_reg   <= '0;
                        den_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DOT;
                    end
                end
                S_DOT: begin
                    num_reg <= num_reg + tnum;
                    den_reg <= den_reg + 18'(tden);
                    if (cnt_reg == 6'd2) begin
                        cnt_reg <= '0;
                        state_reg <= S_RES;
                        if ((num_reg + tnum) <= 0 || (den_reg + 18'(tden)) == '0) begin
                            alpha_reg <= '0;
                        end else if ((num_reg + tnum) >= $signed({2'b0, den_reg + 18'(tden)})) begin
                            alpha_reg <= AW'(mscs_pkg::ONE_Q16);
                        end else begin
                            rem_reg   <= W'(18'(num_reg + tnum));
                            src_reg   <= '0;
                            quo_reg   <= '0;
                            dvs_reg   <= NW'(den_reg + 18'(tden));
                            cnt_reg   <= 6'd16;
                            state_reg <= S_ADIV;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_ADIV: begin
                    rem_reg <= newrem;
                    quo_reg <= quo_next;
                    src_reg <= src_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        alpha_reg <= AW'(quo_next[15:0]);
                        cnt_reg   <= '0;
                        state_reg <= S_RES;
                    end
                end
                S_RES: begin
                    if (!cnt_reg[0]) begin
                        absr_reg <= ar_c[RW-1:0];
                        if (cnt_reg == '0) begin
                            src_reg <= '0;
                        end
                    end else begin
                        src_reg <= src_reg + SRCW'(absr_reg * absr_reg);
                    end
                    if (cnt_reg == 6'd5) begin
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= 6'(RW);
                        state_reg <= S_CSQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_CSQRT: begin
                    rem_reg <= newrem;
                    quo_reg <= quo_next;
                    src_reg <= src_reg << 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        cost_reg  <= CSW'(quo_next[RW-1:8]);
                        sel_reg   <= 1'b0;
                        state_reg <= S_DPREP;
                    end
                end
                S_DPREP: begin
                    src_reg   <= SRCW'({d2, 16'b0}) << (SRCW - QW);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    dvs_reg   <= (near == '0) ? NW'(1) : near;
                    cnt_reg   <= 6'(QW);
                    state_reg <= S_DDIV;
                end
                S_DDIV: begin
                    rem_reg <= newrem;
                    quo_reg <= quo_next;
                    src_reg <= src_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        src_reg   <= SRCW'(quo_next) << (SRCW - SQW);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= 6'(SQW / 2);
                        state_reg <= S_DSQRT;
                    end
                end
                S_DSQRT: begin
                    rem_reg <= newrem;
                    quo_reg <= quo_next;
                    src_reg <= src_reg << 2;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        cost_reg <= cost_reg + CSW'(quo_next[RW-1:0]);
                        if (sel_reg) begin
                            state_reg <= S_DONE;
                        end else begin
                            sel_reg   <= 1'b1;
                            state_reg <= S_DPREP;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        if (better) begin
                            kfg_reg    <= fidx_reg[KIW-1:0];
                            kbg_reg    <= bidx_reg[KIW-1:0];
                            kalpha_reg <= alpha_reg;
                            kcost_reg  <= cost_sat;
                            m_tdata    <= {7'b0, cost_sat, alpha_reg,
                                           16'(bidx_reg[KIW-1:0]), 16'(fidx_reg[KIW-1:0])};
                        end else if (start_reg) begin
                            kfg_reg    <= '0;
                            kbg_reg    <= '0;
                            kalpha_reg <= '0;
                            kcost_reg  <= mscs_pkg::COST_MAX;
                            m_tdata    <= {7'b0, mscs_pkg::COST_MAX, 17'b0, 16'b0, 16'b0};
                        end else begin
                            m_tdata    <= {7'b0, kcost_reg, kalpha_reg, 16'(kbg_reg), 16'(kfg_reg)};
                        end
                        m_tuser   <= better;
                        m_tvalid  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        kalpha_reg <= AW'(mscs_pkg::ONE_Q16))
        else $error("kept alpha above one");

    a_improved_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[72:49] != mscs_pkg::COST_MAX)
        else $error("improved pair with empty cost");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");

endmodule

>>> bench/matting_sample_cost_select_tb.sv
module matting_sample_cost_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CBITS     = mscs_pkg::COORD_BITS_DEF;
    localparam int COLOR_W   = mscs_pkg::COLOR_W;
    localparam int POS_W     = mscs_pkg::POS_W;
    localparam int IDX_W     = mscs_pkg::IDX_W;
    localparam int NEAR_W    = mscs_pkg::NEAR_W;
    localparam int ALPHA_W   = mscs_pkg::ALPHA_W;
    localparam int COST_W    = mscs_pkg::COST_W;
    localparam int S_TDATA_W = mscs_pkg::S_TDATA_W;
    localparam int M_TDATA_W = mscs_pkg::M_TDATA_W;
    localparam int N_RAND = 530;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        bit                start;
        bit [COLOR_W-1:0]  pix_c, fg_c, bg_c;
        bit [POS_W-1:0]    pix_p, fg_p, bg_p;
        bit [IDX_W-1:0]    fg_i, bg_i;
        bit [NEAR_W-1:0]   fg_n, bg_n;
    } cand_t;

    typedef struct {
        bit [IDX_W-1:0]   fg, bg;
        bit [ALPHA_W-1:0] alpha;
        bit [COST_W-1:0]  cost;
        bit               improved;
    } kept_t;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    cand_t  pending_cands[$];
    kept_t  expected_kept[$];
    kept_t  best;
    int     fed = 0, got = 0, errors = 0, improvements = 0;
    int     phase = 0;
    bit     stim_done = 0;
    bit     hold_trig = 0, hold_off = 0;
    int     hold_cnt = 0;
    longint cycles = 0;

    matting_sample_cost_select i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint span_cost(bit [POS_W-1:0] p0, bit [POS_W-1:0] p1,
                                         bit [NEAR_W-1:0] near2);
        longint msk, dx, dy, n;
        msk = (longint'(1) << CBITS) - 1;
        dx = (longint'(p0) & msk) - (longint'(p1) & msk);
        dy = ((longint'(p0) >> CBITS) & msk) - ((longint'(p1) >> CBITS) & msk);
        if (near2 == 0) n = 1;
        else n = longint'(near2);
        return int_sqrt(64'(((dx * dx + dy * dy) << 16) / n));
    endfunction

    function automatic kept_t select_pair(cand_t c);
        longint num, den, alpha, iv, fv, bv, r;
        longint unsigned sumsq, cost;
        kept_t o;
        num = 0; den = 0; sumsq = 0;
        if (c.start) begin
            best = '{fg: 0, bg: 0, alpha: 0, cost: mscs_pkg::COST_MAX, improved: 0};
        end
        for (int k = 0; k < 3; k++) begin
            iv = longint'(c.pix_c[8*k +: 8]);
            fv = longint'(c.fg_c[8*k +: 8]);
            bv = longint'(c.bg_c[8*k +: 8]);
            num += (iv - bv) * (fv - bv);
            den += (fv - bv) * (fv - bv);
        end
        if (num <= 0 || den == 0) alpha = 0;
        else begin
            alpha = (num * mscs_pkg::ONE_Q16) / den;
            if (alpha > mscs_pkg::ONE_Q16) alpha = mscs_pkg::ONE_Q16;
        end
        for (int k = 0; k < 3; k++) begin
            iv = longint'(c.pix_c[8*k +: 8]);
            fv = longint'(c.fg_c[8*k +: 8]);
            bv = longint'(c.bg_c[8*k +: 8]);
            r = iv * mscs_pkg::ONE_Q16 - (bv * mscs_pkg::ONE_Q16 + alpha * (fv - bv));
            if (r < 0) r = -r;
            sumsq += 64'(r * r);
        end
        cost = 64'(int_sqrt(sumsq) >> 8) + 64'(span_cost(c.pix_p, c.fg_p, c.fg_n))
               + 64'(span_cost(c.pix_p, c.bg_p, c.bg_n));
        if (cost > 64'(mscs_pkg::COST_MAX)) cost = 64'(mscs_pkg::COST_MAX);
        best.improved = cost < 64'(best.cost);
        if (best.improved) begin
            best.fg = c.fg_i;
            best.bg = c.bg_i;
            best.alpha = ALPHA_W'(alpha);
            best.cost = COST_W'(cost);
        end
        o = best;
        return o;
    endfunction

    function automatic cand_t rand_cand();
        cand_t c;
        bit [POS_W-1:0] base;
        c.start = ($urandom_range(7) == 0);
        c.pix_c = COLOR_W'($urandom);
        c.fg_c = COLOR_W'($urandom);
        c.bg_c = COLOR_W'($urandom);
        case ($urandom_range(9))
            0: c.bg_c = c.fg_c;
            1: c.pix_c = c.fg_c;
            2: c.pix_c = c.bg_c;
            default: ;
        endcase
        base = POS_W'($urandom);
        if ($urandom_range(1) != 0) begin
            c.pix_p = base;
            c.fg_p = base ^ POS_W'($urandom_range(255) | ($urandom_range(255) << CBITS));
            c.bg_p = base ^ POS_W'($urandom_range(255) | ($urandom_range(255) << CBITS));
        end else begin
            c.pix_p = POS_W'($urandom);
            c.fg_p = POS_W'($urandom);
            c.bg_p = POS_W'($urandom);
        end
        c.fg_i = IDX_W'($urandom);
        c.bg_i = IDX_W'($urandom);
        c.fg_n = $urandom_range(3) == 0 ? NEAR_W'($urandom) : NEAR_W'($urandom_range(20000));
        c.bg_n = $urandom_range(3) == 0 ? NEAR_W'($urandom) : NEAR_W'($urandom_range(20000));
        return c;
    endfunction

    function automatic cand_t mk(bit st, int pc, int fc, int bc, int pp, int fp, int bp,
                                 int fi, int bi, int fn, int bn);
        cand_t c;
        c.start = st;
        c.pix_c = COLOR_W'(pc); c.fg_c = COLOR_W'(fc); c.bg_c = COLOR_W'(bc);
        c.pix_p = POS_W'(pp); c.fg_p = POS_W'(fp); c.bg_p = POS_W'(bp);
        c.fg_i = IDX_W'(fi); c.bg_i = IDX_W'(bi);
        c.fg_n = NEAR_W'(fn); c.bg_n = NEAR_W'(bn);
        return c;
    endfunction

    function automatic void add_cand(cand_t c);
        pending_cands.insert(pending_cands.size(), c);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cands.size() > 0 && !(phase == 0 && $urandom_range(99) < 19)
                && !(phase == 1 && $urandom_range(99) < 78)) begin
                cand_t c;
                c = pending_cands.pop_front();
                expected_kept.insert(expected_kept.size(), select_pair(c));
                s_tvalid <= 1;
                s_tuser <= c.start;
                s_tdata <= {6'd0, c.bg_n, c.fg_n, c.bg_i, c.fg_i, c.bg_p, c.fg_p, c.pix_p,
                            c.bg_c, c.fg_c, c.pix_c};
                fed++;
                phase <= (fed < 183) ? 0 : (fed < 366) ? 1 : 2;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_trig && hold_cnt == 0 && !hold_off) begin
            hold_off <= 1;
            hold_cnt <= 1;
        end else if (hold_off) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 1500) hold_off <= 0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 0;
        else m_tready <= !hold_off && !(phase == 0 && $urandom_range(99) < 78)
                         && !(phase == 1 && $urandom_range(99) < 19);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            kept_t e;
            got++;
            if (got == 400) hold_trig <= 1;
            if (expected_kept.size() == 0) begin
                $error("unexpected word: tdata %h tuser %b", m_tdata, m_tuser);
                errors++;
            end else begin
                e = expected_kept.pop_front();
                if (m_tdata[15:0] !== e.fg) begin
                    $error("best_fg exp %0d got %0d", e.fg, m_tdata[15:0]); errors++;
                end
                if (m_tdata[31:16] !== e.bg) begin
                    $error("best_bg exp %0d got %0d", e.bg, m_tdata[31:16]); errors++;
                end
                if (m_tdata[48:32] !== e.alpha) begin
                    $error("best_alpha exp %0d got %0d", e.alpha, m_tdata[48:32]); errors++;
                end
                if (m_tdata[72:49] !== e.cost) begin
                    $error("best_cost exp %0d got %0d", e.cost, m_tdata[72:49]); errors++;
                end
                if (m_tdata[79:73] !== 7'd0) begin
                    $error("fill exp 0 got %0d", m_tdata[79:73]); errors++;
                end
                if (m_tuser !== e.improved) begin
                    $error("improved exp %0d got %0d", e.improved, m_tuser); errors++;
                end
                if (e.improved) improvements++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", expected_kept.size());
            $display("matting_sample_cost_select_tb: errors");
            $finish;
        end
    end

    initial begin
        best = '{fg: 0, bg: 0, alpha: 0, cost: mscs_pkg::COST_MAX, improved: 0};
        // corners and special cases
        add_cand(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_cand(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_cand(mk(1, 'hffffff, 'hffffff, 'hffffff, 'hffffff, 'hffffff,
                    'hffffff, 'hffff, 'hffff, 'h1ffffff, 'h1ffffff));
        add_cand(mk(1, 'hffffff, 'hffffff, 0, 0, 'hffffff, 'hffffff,
                    1, 2, 1, 1));
        add_cand(mk(0, 0, 'hffffff, 0, 'h00f00f, 'h00f00f, 'h00f00f,
                    3, 4, 5, 5));
        add_cand(mk(0, 'h808080, 'h404040, 0, 'h00f00f, 'h00f00f,
                    'h00f00f, 5, 6, 1, 1));
        add_cand(mk(0, 'h102030, 'h102030, 'h102030, 0, 0, 0, 7, 8, 9, 9));
        add_cand(mk(1, 'h000000, 'hffffff, 'h808080, 'h123456, 'h123456,
                    'h123456, 9, 10, 1, 1));
        add_cand(mk(0, 'h102030, 'h302010, 'h203040, 'h001001, 'h002003,
                    'h004001, 11, 12, 33538050, 33538050));
        add_cand(mk(1, 'h112233, 'h445566, 'h778899, 0, 'hffffff,
                    'hfff000, 'hffff, 0, 1, 1));
        add_cand(mk(0, 'h112233, 'h445566, 'h778899, 0, 'hffffff,
                    'hfff000, 0, 'hffff, 1, 1));
        add_cand(mk(1, 'h112233, 'h445566, 'h778899, 'h00a00a, 'h00a00b,
                    'h00b00a, 13, 14, 2, 2));
        add_cand(mk(0, 'h112233, 'h445566, 'h778899, 'h00a00a, 'h00a00b,
                    'h00b00a, 15, 16, 2, 2));
        add_cand(mk(0, 'h00ff00, 'h0000ff, 'hff0000, 'hfff000, 'h000fff,
                    'hfff000, 17, 18, 1, 'h1ffffff));
        add_cand(mk(0, 'hffffff, 0, 'hffffff, 'h000fff, 'hfff000, 0,
                    19, 20, 0, 'h1ffffff));
        for (int n = 0; n < N_RAND; n++) add_cand(rand_cand());
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        wait (pending_cands.size() == 0 && expected_kept.size() == 0);
        repeat (600) @(posedge aclk);
        $display("%0d candidates checked, %0d improved the kept pair, long output stall seen",
                 got, improvements);
        if (errors == 0 && expected_kept.size() == 0)
            $display("matting_sample_cost_select_tb: clean");
        else
            $display("matting_sample_cost_select_tb: errors");
        $finish;
    end
endmodule
